[hw/rtl/bfrt_pkg.sv]
package bfrt_pkg;

	localparam int LANE_BITS = 8;
	localparam int FRAC_BITS = 16;
	localparam int NUM_W     = 32;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int ACC_W     = FRAC_BITS + NUM_W;
	localparam int CHUNK_W   = 7;

	// Per-cycle commands from the sequencer to every lane
	typedef struct packed {
		logic clr;
		logic rd;
		logic load;
		logic step;
		logic wr;
		logic upd;
	} lane_cmd_t;

endpackage

[hw/rtl/bit_flip_rarity_tracker.sv]
// Bit flip rarity tracker.
// Input channel (in_valid/in_ready) takes one chunk of eight feature bits
// with the previous and current values, its chunk index, the frame number
// and a last-chunk mark. Output channel (out_valid/out_ready) returns one
// result per chunk: rare and plain rise/fall masks, and on the last chunk
// whether any rare flip was seen in the frame.
// Configuration: cfg_we with cfg_index 0 writes rarity_threshold, index 1
// writes warmup_frames; write only while the block is idle.
// Sequence: the memory read at the transfer edge, a divider load, the
// per-lane restoring divider steps, one per quotient bit, and a write-back.
// One chunk is in flight at a time: in_ready returns in the cycle after
// write-back, so a new chunk is not taken until the last is written back.
// Reset: the frequency stores are zeroed by a clearing pass over all
// ceil(FRAME_BITS/8) rows (128 by default) during which in_ready is low.
// Stall: a result waits in the output register; the next chunk is accepted
// and processed meanwhile, and holds at write-back until the slot frees.
module bit_flip_rarity_tracker #(
	parameter int FRAME_BITS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  prev_bits,
	input  logic [7:0]  cur_bits,
	input  logic [6:0]  chunk_index,
	input  logic [31:0] frame_number,
	input  logic        last_chunk,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  out_chunk,
	output logic [7:0]  rare_rise,
	output logic [7:0]  rare_fall,
	output logic [7:0]  flip_rise,
	output logic [7:0]  flip_fall,
	output logic        frame_has_rare,
	output logic        last
);

	localparam int LB   = bfrt_pkg::LANE_BITS;
	localparam int ROWS = (FRAME_BITS + LB - 1) / LB;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int QW   = bfrt_pkg::QUO_W;
	localparam int CW   = $clog2(QW);

	localparam logic [0:0] REG_THRESH = 1'd0;
	localparam logic [0:0] REG_WARMUP = 1'd1;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;

	logic [2:0]                       state_q;
	logic [AW-1:0]                    clr_q;
	logic [CW-1:0]                    cnt_q;
	logic [bfrt_pkg::FRAC_BITS-1:0]   thresh_q;
	logic [31:0]                      warm_q;
	logic [LB-1:0]                    rise_q;
	logic [LB-1:0]                    fall_q;
	logic [6:0]                       chunk_q;
	logic [31:0]                      n_q;
	logic                             last_q;
	logic                             judge_q;
	logic                             upd_q;
	logic                             accept;
	logic                             commit;
	logic [AW-1:0]                    mem_addr;
	logic [LB-1:0]                    lane_rare_r;
	logic [LB-1:0]                    lane_rare_f;
	bfrt_pkg::lane_cmd_t              cmd;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == S_WB) && (!out_valid || out_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
			warm_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESH: thresh_q <= cfg_data[bfrt_pkg::FRAC_BITS-1:0];
				REG_WARMUP: warm_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: clear pass, then read, multiply, divide, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ROWS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept)
						state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QW - 1))
						state_q <= S_WB;
				end
				S_WB: begin
					if (commit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the chunk at the input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			rise_q  <= ~prev_bits & cur_bits;
			fall_q  <= prev_bits & ~cur_bits;
			chunk_q <= chunk_index;
			n_q     <= frame_number;
			last_q  <= last_chunk;
			judge_q <= frame_number > warm_q;
			upd_q   <= frame_number != 32'd0;
		end
	end

	always_comb begin
		cmd.clr  = (state_q == S_CLR);
		cmd.rd   = accept;
		cmd.load = (state_q == S_MUL);
		cmd.step = (state_q == S_DIV);
		cmd.wr   = commit;
		cmd.upd  = upd_q;
		if (state_q == S_CLR)
			mem_addr = clr_q;
		else if (state_q == S_IDLE)
			mem_addr = AW'(chunk_index);
		else
			mem_addr = AW'(chunk_q);
	end

	for (genvar l = 0; l < LB; l++) begin : g_lane
		bfrt_lane #(
			.FRAME_BITS (FRAME_BITS),
			.ROWS       (ROWS),
			.AW         (AW),
			.LANE       (l)
		) u_lane (
			.clk    (clk),
			.cmd    (cmd),
			.addr   (mem_addr),
			.chunk  (chunk_q),
			.n      (n_q),
			.flip_r (rise_q[l]),
			.flip_f (fall_q[l]),
			.thresh (thresh_q),
			.judge  (judge_q),
			.rare_r (lane_rare_r[l]),
			.rare_f (lane_rare_f[l])
		);
	end

	bfrt_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (commit),
		.lane_rare_r    (lane_rare_r),
		.lane_rare_f    (lane_rare_f),
		.lane_flip_r    (rise_q),
		.lane_flip_f    (fall_q),
		.chunk          (chunk_q),
		.last_in        (last_q),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_chunk      (out_chunk),
		.rare_rise      (rare_rise),
		.rare_fall      (rare_fall),
		.flip_rise      (flip_rise),
		.flip_fall      (flip_fall),
		.frame_has_rare (frame_has_rare),
		.last           (last)
	);

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_MUL)
		else $error("transfer did not start the multiply cycle");

	a_rise_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_WB))
		else $error("result appeared without write-back");

	a_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !frame_has_rare)
		else $error("frame flag set on a chunk that is not last");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> cnt_q <= CW'(QW - 1))
		else $error("divider step count overran");

endmodule

[hw/rtl/bfrt_div.sv]
module bfrt_div (
	input  logic                           clk,
	input  logic                           load,
	input  logic                           step,
	input  logic [bfrt_pkg::ACC_W-1:0]     acc,
	input  logic [bfrt_pkg::NUM_W-1:0]     den,
	output logic [bfrt_pkg::QUO_W-1:0]     quo
);

	localparam int QW = bfrt_pkg::QUO_W;
	localparam int NW = bfrt_pkg::NUM_W;
	localparam int AW = bfrt_pkg::ACC_W;

	logic [NW-1:0] rem_q;
	logic [QW-1:0] dq_q;
	logic [NW:0]   trial;
	logic          ge;

	// One restoring step: shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dq_q[QW-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {1'b0, acc[AW-1:QW]};
			dq_q  <= acc[QW-1:0];
		end else if (step) begin
			rem_q <= ge ? NW'(trial - {1'b0, den}) : trial[NW-1:0];
			dq_q  <= {dq_q[QW-2:0], ge};
		end
	end

	assign quo = dq_q;

endmodule

[hw/rtl/bfrt_lane.sv]
module bfrt_lane #(
	parameter int FRAME_BITS = 1024,
	parameter int ROWS       = 128,
	parameter int AW         = 7,
	parameter int LANE       = 0
) (
	input  logic                              clk,
	input  bfrt_pkg::lane_cmd_t               cmd,
	input  logic [AW-1:0]                     addr,
	input  logic [bfrt_pkg::CHUNK_W-1:0]      chunk,
	input  logic [bfrt_pkg::NUM_W-1:0]        n,
	input  logic                              flip_r,
	input  logic                              flip_f,
	input  logic [bfrt_pkg::FRAC_BITS-1:0]    thresh,
	input  logic                              judge,
	output logic                              rare_r,
	output logic                              rare_f
);

	localparam int FB = bfrt_pkg::FRAC_BITS;
	localparam int QW = bfrt_pkg::QUO_W;
	localparam int AC = bfrt_pkg::ACC_W;
	localparam logic [AC-1:0] ONE = AC'(1) << FB;

	logic [FB-1:0] mem_r [ROWS];
	logic [FB-1:0] mem_f [ROWS];
	logic [FB-1:0] rd_r_q;
	logic [FB-1:0] rd_f_q;
	logic [AC-1:0] acc_r;
	logic [AC-1:0] acc_f;
	logic [QW-1:0] quo_r;
	logic [QW-1:0] quo_f;
	logic [FB-1:0] sat_r;
	logic [FB-1:0] sat_f;
	logic [31:0]   bit_idx;
	logic          in_range;

	// Global bit index of this lane; lanes past the frame end keep no state
	assign bit_idx  = 32'(chunk) * 32'(bfrt_pkg::LANE_BITS) + 32'(LANE);
	assign in_range = bit_idx < 32'(FRAME_BITS);

	// Frequency stores: clear pass, read at transfer, write back at commit (not for frame 0)
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem_r[addr] <= '0;
			mem_f[addr] <= '0;
		end else if (cmd.wr && cmd.upd && in_range) begin
			mem_r[addr] <= sat_r;
			mem_f[addr] <= sat_f;
		end
		if (cmd.rd) begin
			rd_r_q <= mem_r[addr];
			rd_f_q <= mem_f[addr];
		end
	end

	// Weighted old mean plus the new flip, registered inside the dividers
	assign acc_r = AC'(rd_r_q) * AC'(n - 32'd1) + (flip_r ? ONE : '0);
	assign acc_f = AC'(rd_f_q) * AC'(n - 32'd1) + (flip_f ? ONE : '0);

	bfrt_div u_div_r (
		.clk  (clk),
		.load (cmd.load),
		.step (cmd.step),
		.acc  (acc_r),
		.den  (n),
		.quo  (quo_r)
	);

	bfrt_div u_div_f (
		.clk  (clk),
		.load (cmd.load),
		.step (cmd.step),
		.acc  (acc_f),
		.den  (n),
		.quo  (quo_f)
	);

	// Saturate a mean of exactly one to all ones
	assign sat_r = quo_r[QW-1] ? '1 : quo_r[FB-1:0];
	assign sat_f = quo_f[QW-1] ? '1 : quo_f[FB-1:0];

	assign rare_r = flip_r && judge && cmd.upd && in_range && (sat_r < thresh);
	assign rare_f = flip_f && judge && cmd.upd && in_range && (sat_f < thresh);

endmodule

[hw/rtl/bfrt_merge.sv]
module bfrt_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                commit,
	input  logic [bfrt_pkg::LANE_BITS-1:0]      lane_rare_r,
	input  logic [bfrt_pkg::LANE_BITS-1:0]      lane_rare_f,
	input  logic [bfrt_pkg::LANE_BITS-1:0]      lane_flip_r,
	input  logic [bfrt_pkg::LANE_BITS-1:0]      lane_flip_f,
	input  logic [bfrt_pkg::CHUNK_W-1:0]        chunk,
	input  logic                                last_in,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [bfrt_pkg::CHUNK_W-1:0]        out_chunk,
	output logic [bfrt_pkg::LANE_BITS-1:0]      rare_rise,
	output logic [bfrt_pkg::LANE_BITS-1:0]      rare_fall,
	output logic [bfrt_pkg::LANE_BITS-1:0]      flip_rise,
	output logic [bfrt_pkg::LANE_BITS-1:0]      flip_fall,
	output logic                                frame_has_rare,
	output logic                                last
);

	logic rare_seen_q;
	logic any_rare;

	assign any_rare = |{lane_rare_r, lane_rare_f};

	// Track rare flips across the frame, drop the flag after the last chunk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rare_seen_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (commit) begin
				rare_seen_q <= last_in ? 1'b0 : (rare_seen_q | any_rare);
				out_valid   <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Hold the result payload until the transfer
	always_ff @(posedge clk) begin
		if (commit) begin
			out_chunk      <= chunk;
			rare_rise      <= lane_rare_r;
			rare_fall      <= lane_rare_f;
			flip_rise      <= lane_flip_r;
			flip_fall      <= lane_flip_f;
			frame_has_rare <= last_in && (rare_seen_q || any_rare);
			last           <= last_in;
		end
	end

endmodule
